/* rtl/scpg_pkg.sv */
// ----------------------------------------------------------------------------
// scpg_pkg
// Types and constants shared by the stepper command pulse generator modules.
// ----------------------------------------------------------------------------
package scpg_pkg;

    // command bytes
    localparam logic [7:0] OP_SET_ADDR   = 8'hA1;
    localparam logic [7:0] OP_SET_DUR    = 8'hA2;
    localparam logic [7:0] OP_MOVE_FWD   = 8'hB1;
    localparam logic [7:0] OP_MOVE       = 8'hB2;
    localparam logic [7:0] OP_READ_ADC8  = 8'hC1;
    localparam logic [7:0] OP_READ_ADC10 = 8'hC2;

    localparam logic [6:0]  ADDR_RESET    = 7'h10;
    localparam logic [7:0]  ADDR_MIN      = 8'd7;
    localparam logic [7:0]  ADDR_MAX      = 8'd77;
    localparam logic [15:0] DURATION_RESET = 16'd50;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // parser phase
    typedef enum logic [2:0] {
        PH_CMD  = 3'b001,
        PH_ARG1 = 3'b010,
        PH_ARG2 = 3'b100
    } phase_t;

    // command waiting for its arguments
    typedef enum logic [1:0] {
        PEND_ADDR = 2'd0,
        PEND_DUR  = 2'd1,
        PEND_MOVE = 2'd2
    } pend_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
        logic [9:0] adc_value;
    } cmd_t;

    typedef struct packed {
        logic       step_pin;
        logic       dir_pin;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [6:0] bus_address;
        logic       busy_res;
        logic       dropped;
        logic       last;
    } res_t;

    // ctrl to output stage
    typedef struct packed {
        logic       two;
        logic [7:0] hi_byte;
    } extra_t;

endpackage

/* rtl/scpg_ctrl.sv */
// ----------------------------------------------------------------------------
// scpg_ctrl
// Command parser and step timing state; updates once per transferred item.
// ----------------------------------------------------------------------------
module scpg_ctrl
    import scpg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  cmd_t   item,
    output res_t   res,
    output extra_t extra
);

    logic [6:0]  addr_reg,   addr_next;
    logic [15:0] dur_reg,    dur_next;
    phase_t      phase_reg,  phase_next;
    pend_t       pend_reg,   pend_next;
    logic [7:0]  hi_reg,     hi_next;
    logic [15:0] steps_reg,  steps_next;
    logic [14:0] ticks_reg,  ticks_next;
    logic        step_reg,   step_next;
    logic        dir_reg,    dir_next;
    logic        moving_reg, moving_next;

    logic [14:0] half;
    logic [14:0] ticks_dec;
    logic [15:0] steps_dec;
    logic [15:0] arg16;

    assign half      = dur_reg[15:1];
    assign ticks_dec = (ticks_reg != 15'd0) ? ticks_reg - 15'd1 : 15'd0;
    assign steps_dec = steps_reg - 16'd1;
    assign arg16     = {hi_reg, item.rx_byte};

    always_comb
    begin
        addr_next   = addr_reg;
        dur_next    = dur_reg;
        phase_next  = phase_reg;
        pend_next   = pend_reg;
        hi_next     = hi_reg;
        steps_next  = steps_reg;
        ticks_next  = ticks_reg;
        step_next   = step_reg;
        dir_next    = dir_reg;
        moving_next = moving_reg;
        res         = '0;
        extra       = '0;

        if (item.action == ACT_TICK)
        begin
            if (moving_reg)
            begin
                ticks_next = ticks_dec;
                if (ticks_dec == 15'd0)
                begin
                    if (step_reg)
                    begin
                        step_next  = 1'b0;
                        ticks_next = half;
                    end
                    else
                    begin
                        steps_next = steps_dec;
                        step_next  = 1'b1;
                        ticks_next = half;
                    end
                    // last step done, or zero half period
                    if ((!step_reg && steps_dec == 16'd0) || half == 15'd0)
                    begin
                        moving_next = 1'b0;
                        step_next   = 1'b0;
                        steps_next  = 16'd0;
                        ticks_next  = 15'd0;
                        dir_next    = 1'b0;
                    end
                end
            end
        end
        else if (moving_reg)
        begin
            res.dropped = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_CMD:
                begin
                    unique case (item.rx_byte)
                        OP_SET_ADDR:
                        begin
                            pend_next  = PEND_ADDR;
                            phase_next = PH_ARG1;
                        end
                        OP_SET_DUR:
                        begin
                            pend_next  = PEND_DUR;
                            phase_next = PH_ARG1;
                        end
                        OP_MOVE_FWD:
                        begin
                            dir_next   = 1'b1;
                            pend_next  = PEND_MOVE;
                            phase_next = PH_ARG1;
                        end
                        OP_MOVE:
                        begin
                            pend_next  = PEND_MOVE;
                            phase_next = PH_ARG1;
                        end
                        OP_READ_ADC8:
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = item.adc_value[9:2];
                        end
                        OP_READ_ADC10:
                        begin
                            res.tx_valid  = 1'b1;
                            res.tx_byte   = item.adc_value[7:0];
                            extra.two     = 1'b1;
                            extra.hi_byte = {6'd0, item.adc_value[9:8]};
                        end
                        default:
                        begin
                        end
                    endcase
                end
                PH_ARG1:
                begin
                    unique case (pend_reg)
                        PEND_ADDR:
                        begin
                            if (item.rx_byte >= ADDR_MIN && item.rx_byte <= ADDR_MAX)
                                addr_next = item.rx_byte[6:0];
                            phase_next = PH_CMD;
                        end
                        PEND_DUR, PEND_MOVE:
                        begin
                            hi_next    = item.rx_byte;
                            phase_next = PH_ARG2;
                        end
                        default: phase_next = PH_CMD;
                    endcase
                end
                PH_ARG2:
                begin
                    if (pend_reg == PEND_DUR)
                        dur_next = arg16;
                    else if (pend_reg == PEND_MOVE)
                    begin
                        if (half == 15'd0 || arg16 == 16'd0)
                        begin
                            moving_next = 1'b0;
                            step_next   = 1'b0;
                            steps_next  = 16'd0;
                            ticks_next  = 15'd0;
                            dir_next    = 1'b0;
                        end
                        else
                        begin
                            moving_next = 1'b1;
                            steps_next  = arg16;
                            step_next   = 1'b1;
                            ticks_next  = half;
                        end
                    end
                    phase_next = PH_CMD;
                end
                default: phase_next = PH_CMD;
            endcase
        end

        // every result reports the state after the item
        res.step_pin    = step_next;
        res.dir_pin     = dir_next;
        res.bus_address = addr_next;
        res.busy_res    = moving_next;
        res.last        = !extra.two;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= ADDR_RESET;
            dur_reg    <= DURATION_RESET;
            phase_reg  <= PH_CMD;
            pend_reg   <= PEND_ADDR;
            hi_reg     <= 8'd0;
            steps_reg  <= 16'd0;
            ticks_reg  <= 15'd0;
            step_reg   <= 1'b0;
            dir_reg    <= 1'b0;
            moving_reg <= 1'b0;
        end
        else if (advance)
        begin
            addr_reg   <= addr_next;
            dur_reg    <= dur_next;
            phase_reg  <= phase_next;
            pend_reg   <= pend_next;
            hi_reg     <= hi_next;
            steps_reg  <= steps_next;
            ticks_reg  <= ticks_next;
            step_reg   <= step_next;
            dir_reg    <= dir_next;
            moving_reg <= moving_next;
        end
    end

    // a running move always has a step and a phase left
    assert property (@(posedge clk) disable iff (!rst_n)
        moving_reg |-> (steps_reg != 16'd0 && ticks_reg != 15'd0))
        else $error("move running with empty counters");

    assert property (@(posedge clk) disable iff (!rst_n)
        addr_reg >= ADDR_MIN[6:0] && addr_reg <= ADDR_MAX[6:0])
        else $error("bus address out of range");

    // step pin only toggles during a move
    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg |-> moving_reg)
        else $error("step pin high while idle");

endmodule

/* rtl/stepper_command_pulse_generator_core.sv */
// ----------------------------------------------------------------------------
// stepper_command_pulse_generator_core
// Bus command decoder and stepper pulse generator with a result register.
// ----------------------------------------------------------------------------
// Each transfer on cmd is a received bus byte or a one-millisecond tick. The
// block takes one item per clock unless cmd is stalled and shows its result
// in the next cycle in the result register; a new item is taken while that
// result waits, as long as it leaves the register in the same cycle. A 0xC2
// query fills the result register with two results, low byte then high byte;
// cmd stalls while the low byte waits. All other items give one result.
module stepper_command_pulse_generator_core
    import scpg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    res_t       res_comb;
    extra_t     extra;
    logic       take;
    logic       drain;

    logic       out_valid_reg,  out_valid_next;
    res_t       out_reg,        out_next;
    logic       second_reg,     second_next;
    logic [7:0] hi_byte_reg,    hi_byte_next;

    assign drain     = out_valid_reg && !res_stall;
    assign cmd_stall = out_valid_reg && (res_stall || second_reg);
    assign take      = cmd_valid && !cmd_stall;

    scpg_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (take),
        .item    (cmd),
        .res     (res_comb),
        .extra   (extra)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        second_next    = second_reg;
        hi_byte_next   = hi_byte_reg;
        priority if (drain && second_reg)
        begin
            // second half of the two-byte reply
            out_next.tx_byte = hi_byte_reg;
            out_next.last    = 1'b1;
            second_next      = 1'b0;
        end
        else if (take)
        begin
            out_valid_next = 1'b1;
            out_next       = res_comb;
            second_next    = extra.two;
            hi_byte_next   = extra.hi_byte;
        end
        else if (drain)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        hi_byte_reg <= hi_byte_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (out_valid_reg && !out_reg.last && out_reg.tx_valid))
        else $error("pending high byte without a shown low byte");

    // the high byte follows the low byte in the very next transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (drain && second_reg) |=> (out_valid_reg && out_reg.last && !second_reg))
        else $error("high byte not shown after low byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !second_reg) |-> out_reg.last)
        else $error("single result not marked last");

endmodule

/* sim/tb_stepper_command_pulse_generator_core.sv */
// ----------------------------------------------------------------------------
// tb_stepper_command_pulse_generator_core
// Self-checking bench for the stepper command decoder and pulse generator.
// ----------------------------------------------------------------------------
// A directed table walks the address, duration, move and query commands, a
// byte dropped during a move and the empty-move case. A few rows carry a
// hand-typed result. After the table comes a random mix of well-formed
// command sequences, ticks and noise bytes. Each result transfer is checked,
// field by field, against a typed result or a local model of the command
// parser and the step timer. Both sides idle at random, and the result side
// holds off once for a long stretch so that the block backs up and stalls cmd.
module tb_stepper_command_pulse_generator_core
    import scpg_pkg::*;
();

    localparam int RANDOM_ITEMS = 550;
    localparam int IDLE_LIMIT   = 1000;
    localparam int LONG_HOLD    = 150;
    localparam int DRAIN_CYCLES = 8;

    localparam res_t PLAIN_AFTER_RESET = '{step_pin: 1'b0, dir_pin: 1'b0, tx_valid: 1'b0,
                                           tx_byte: 8'h00, bus_address: ADDR_RESET,
                                           busy_res: 1'b0, dropped: 1'b0, last: 1'b1};
    localparam res_t ADC_FULL_SCALE = '{step_pin: 1'b0, dir_pin: 1'b0, tx_valid: 1'b1,
                                        tx_byte: 8'hFF, bus_address: ADDR_RESET,
                                        busy_res: 1'b0, dropped: 1'b0, last: 1'b1};

    typedef struct {
        cmd_t item;
        bit   typed;
        res_t result;
    } table_row_t;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic res_valid;
    logic res_stall;
    res_t res;

    // expectation for the item on cmd, valid while row_typed is set
    logic row_typed;
    res_t row_exp;

    // model of the block
    logic [6:0]  cur_addr;
    logic [15:0] cur_duration;
    phase_t      parser_phase;
    pend_t       arg_owner;
    logic [7:0]  arg_high;
    logic [15:0] steps_to_go;
    logic [14:0] phase_ticks;
    logic        step_out;
    logic        dir_out;
    logic        in_motion;

    res_t item_results[2];
    int   item_result_count;
    res_t expected_results[$];

    table_row_t directed_rows[$];
    int  mismatches;
    int  results_seen;
    int  idle_cycles;
    bit  long_hold;
    bit  long_hold_done;
    bit  sender_quiet;
    bit  receiver_quiet;

    stepper_command_pulse_generator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic res_t status_word(bit txv, logic [7:0] txb, bit drop, bit fin);
        res_t r;
        r.step_pin    = step_out;
        r.dir_pin     = dir_out;
        r.tx_valid    = txv;
        r.tx_byte     = txv ? txb : 8'h00;
        r.bus_address = cur_addr;
        r.busy_res    = in_motion;
        r.dropped     = drop;
        r.last        = fin;
        return r;
    endfunction

    task automatic stop_motion();
        in_motion   = 1'b0;
        step_out    = 1'b0;
        steps_to_go = '0;
        phase_ticks = '0;
        dir_out     = 1'b0;
    endtask

    task automatic reset_stepper_model();
        cur_addr     = ADDR_RESET;
        cur_duration = DURATION_RESET;
        parser_phase = PH_CMD;
        arg_owner    = PEND_ADDR;
        arg_high     = '0;
        stop_motion();
    endtask

    // works out the results of one item and advances the model
    task automatic apply_stepper_item(input cmd_t c);
        logic [14:0] half;
        logic [15:0] arg;
        bit          reply8;
        bit          reply10;
        half              = cur_duration[15:1];
        arg               = {arg_high, c.rx_byte};
        reply8            = 1'b0;
        reply10           = 1'b0;
        item_result_count = 1;
        if (c.action == ACT_TICK)
        begin
            if (in_motion)
            begin
                if (phase_ticks != 0)
                    phase_ticks = phase_ticks - 1'b1;
                if (phase_ticks == 0)
                begin
                    if (step_out)
                    begin
                        step_out    = 1'b0;
                        phase_ticks = half;
                    end
                    else
                    begin
                        steps_to_go = steps_to_go - 1'b1;
                        if (steps_to_go == 0)
                            stop_motion();
                        else
                        begin
                            step_out    = 1'b1;
                            phase_ticks = half;
                        end
                    end
                    if (in_motion && phase_ticks == 0)
                        stop_motion();
                end
            end
            item_results[0] = status_word(1'b0, 8'h00, 1'b0, 1'b1);
        end
        else if (in_motion)
            item_results[0] = status_word(1'b0, 8'h00, 1'b1, 1'b1);
        else
        begin
            case (parser_phase)
                PH_CMD:
                begin
                    case (c.rx_byte)
                        OP_SET_ADDR:
                        begin
                            arg_owner    = PEND_ADDR;
                            parser_phase = PH_ARG1;
                        end
                        OP_SET_DUR:
                        begin
                            arg_owner    = PEND_DUR;
                            parser_phase = PH_ARG1;
                        end
                        OP_MOVE_FWD:
                        begin
                            dir_out      = 1'b1;
                            arg_owner    = PEND_MOVE;
                            parser_phase = PH_ARG1;
                        end
                        OP_MOVE:
                        begin
                            arg_owner    = PEND_MOVE;
                            parser_phase = PH_ARG1;
                        end
                        OP_READ_ADC8:  reply8 = 1'b1;
                        OP_READ_ADC10: reply10 = 1'b1;
                        default: ;
                    endcase
                end
                PH_ARG1:
                begin
                    if (arg_owner == PEND_ADDR)
                    begin
                        if (c.rx_byte >= ADDR_MIN && c.rx_byte <= ADDR_MAX)
                            cur_addr = c.rx_byte[6:0];
                        parser_phase = PH_CMD;
                    end
                    else
                    begin
                        arg_high     = c.rx_byte;
                        parser_phase = PH_ARG2;
                    end
                end
                PH_ARG2:
                begin
                    if (arg_owner == PEND_DUR)
                        cur_duration = arg;
                    else if (arg_owner == PEND_MOVE)
                    begin
                        if (half == 0 || arg == 0)
                            stop_motion();
                        else
                        begin
                            in_motion   = 1'b1;
                            steps_to_go = arg;
                            step_out    = 1'b1;
                            phase_ticks = half;
                        end
                    end
                    parser_phase = PH_CMD;
                end
                default: parser_phase = PH_CMD;
            endcase
            if (reply8)
                item_results[0] = status_word(1'b1, c.adc_value[9:2], 1'b0, 1'b1);
            else if (reply10)
            begin
                item_results[0]   = status_word(1'b1, c.adc_value[7:0], 1'b0, 1'b0);
                item_results[1]   = status_word(1'b1, {6'b0, c.adc_value[9:8]}, 1'b0, 1'b1);
                item_result_count = 2;
            end
            else
                item_results[0] = status_word(1'b0, 8'h00, 1'b0, 1'b1);
        end
    endtask

    function automatic bit same_result(res_t a, res_t b);
        return a.step_pin === b.step_pin && a.dir_pin === b.dir_pin
            && a.tx_valid === b.tx_valid && a.tx_byte === b.tx_byte
            && a.bus_address === b.bus_address && a.busy_res === b.busy_res
            && a.dropped === b.dropped && a.last === b.last;
    endfunction

    task automatic note_mismatch(string what, res_t e, res_t g);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch (%s)", what);
            $display("  exp step=%b dir=%b txv=%b txb=%h addr=%0d busy=%b drop=%b last=%b",
                     e.step_pin, e.dir_pin, e.tx_valid, e.tx_byte, e.bus_address,
                     e.busy_res, e.dropped, e.last);
            $display("  got step=%b dir=%b txv=%b txb=%h addr=%0d busy=%b drop=%b last=%b",
                     g.step_pin, g.dir_pin, g.tx_valid, g.tx_byte, g.bus_address,
                     g.busy_res, g.dropped, g.last);
        end
    endtask

    // check result transfers and predict accepted commands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    note_mismatch("no result expected", res, res);
                else if (!same_result(expected_results[0], res))
                    note_mismatch("field", expected_results.pop_front(), res);
                else
                    void'(expected_results.pop_front());
            end
            if (cmd_valid && !cmd_stall)
            begin
                apply_stepper_item(cmd);
                if (row_typed)
                    expected_results.push_back(row_exp);
                else
                    for (int k = 0; k < item_result_count; k++)
                        expected_results.push_back(item_results[k]);
            end
        end
    end

    // ends the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // result side: random hold-off per transfer, one long hold-off
    initial
    begin : result_sink
        int hold;
        res_stall      = 1'b0;
        long_hold      = 1'b0;
        long_hold_done = 1'b0;
        receiver_quiet = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                receiver_quiet = !receiver_quiet;
            if (!long_hold_done && results_seen >= LONG_HOLD)
            begin
                long_hold      = 1'b1;
                long_hold_done = 1'b1;
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                hold = receiver_quiet ? 0 : $urandom_range(0, 13);
                if (hold > 0)
                begin
                    res_stall <= 1'b1;
                    repeat (hold) @(negedge clk);
                end
            end
            res_stall <= 1'b0;
            do
                @(posedge clk);
            while (!res_valid);
            @(negedge clk);
        end
    end

    task automatic add_row(logic act, logic [7:0] b, logic [9:0] adc, bit typed, res_t r);
        table_row_t row;
        row.item.action    = act;
        row.item.rx_byte   = b;
        row.item.adc_value = adc;
        row.typed          = typed;
        row.result         = r;
        directed_rows.push_back(row);
    endtask

    // called at a falling edge, holds valid until the transfer
    task automatic send_item(cmd_t c, bit typed, res_t r);
        int gap;
        if ($urandom_range(0, 39) == 0)
            sender_quiet = !sender_quiet;
        gap = (long_hold || sender_quiet) ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        row_typed <= typed;
        row_exp   <= r;
        do
            @(posedge clk);
        while (cmd_stall);
        @(negedge clk);
    endtask

    // mostly well-formed sequences, short moves, some noise
    function automatic cmd_t next_random_item();
        cmd_t        c;
        int          r;
        logic [14:0] half;
        half        = cur_duration[15:1];
        r           = $urandom_range(0, 99);
        c.action    = ACT_BYTE;
        c.rx_byte   = 8'($urandom_range(0, 255));
        c.adc_value = 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 9) == 0)
            c.adc_value = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
        if (in_motion)
        begin
            if (r < 88)
                c.action = ACT_TICK;
        end
        else if (r >= 92 && parser_phase != PH_CMD)
            c.action = ACT_TICK;
        else
        begin
            case (parser_phase)
                PH_CMD:
                begin
                    if (r < 14)
                        c.rx_byte = OP_SET_ADDR;
                    else if (r < 28)
                        c.rx_byte = OP_SET_DUR;
                    else if (r < 42)
                        c.rx_byte = OP_MOVE_FWD;
                    else if (r < 56)
                        c.rx_byte = OP_MOVE;
                    else if (r < 66)
                        c.rx_byte = OP_READ_ADC8;
                    else if (r < 76)
                        c.rx_byte = OP_READ_ADC10;
                    else if (r < 88)
                        c.action = ACT_TICK;
                end
                PH_ARG1:
                begin
                    if (arg_owner == PEND_ADDR)
                    begin
                        if (r < 70)
                            c.rx_byte = 8'($urandom_range(ADDR_MIN, ADDR_MAX));
                    end
                    else if (arg_owner == PEND_DUR)
                    begin
                        if (r < 85)
                            c.rx_byte = 8'h00;
                    end
                    else if (half != 0 || r < 50)
                        c.rx_byte = 8'h00;
                end
                default:
                begin
                    if (arg_owner == PEND_DUR)
                    begin
                        if (r < 85)
                            c.rx_byte = 8'($urandom_range(0, 9));
                    end
                    // keep moves short, large durations only give empty moves
                    else if (half > 16)
                        c.rx_byte = 8'h00;
                    else if (half != 0)
                        c.rx_byte = 8'($urandom_range(0, 4));
                end
            endcase
        end
        return c;
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        cmd          = '0;
        row_typed    = 1'b0;
        row_exp      = '0;
        mismatches   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        sender_quiet = 1'b0;
        reset_stepper_model();

        add_row(ACT_TICK, 8'h00, 10'h000, 1'b1, PLAIN_AFTER_RESET);
        add_row(ACT_BYTE, 8'h00, 10'h155, 1'b1, PLAIN_AFTER_RESET);
        add_row(ACT_BYTE, 8'hFF, 10'h2AA, 1'b1, PLAIN_AFTER_RESET);
        add_row(ACT_BYTE, OP_READ_ADC8, 10'h3FF, 1'b1, ADC_FULL_SCALE);
        add_row(ACT_BYTE, OP_READ_ADC10, 10'h2AA, 1'b0, '0);
        // address just below the allowed range is swallowed
        add_row(ACT_BYTE, OP_SET_ADDR, 10'h000, 1'b1, PLAIN_AFTER_RESET);
        add_row(ACT_BYTE, 8'h06, 10'h000, 1'b1, PLAIN_AFTER_RESET);
        add_row(ACT_BYTE, OP_SET_ADDR, 10'h000, 1'b0, '0);
        add_row(ACT_BYTE, ADDR_MIN, 10'h000, 1'b0, '0);
        add_row(ACT_BYTE, OP_SET_ADDR, 10'h000, 1'b0, '0);
        add_row(ACT_BYTE, ADDR_MAX, 10'h000, 1'b0, '0);
        add_row(ACT_BYTE, OP_SET_DUR, 10'h000, 1'b0, '0);
        add_row(ACT_BYTE, 8'h00, 10'h000, 1'b0, '0);
        add_row(ACT_BYTE, 8'h02, 10'h000, 1'b0, '0);
        // one-step forward move, a byte dropped on the way
        add_row(ACT_BYTE, OP_MOVE_FWD, 10'h000, 1'b0, '0);
        add_row(ACT_BYTE, 8'h00, 10'h000, 1'b0, '0);
        add_row(ACT_BYTE, 8'h01, 10'h000, 1'b0, '0);
        add_row(ACT_BYTE, OP_READ_ADC8, 10'h3FF, 1'b0, '0);
        add_row(ACT_TICK, 8'hFF, 10'h3FF, 1'b0, '0);
        add_row(ACT_TICK, 8'h00, 10'h000, 1'b0, '0);
        add_row(ACT_BYTE, OP_SET_DUR, 10'h000, 1'b0, '0);
        add_row(ACT_BYTE, 8'hFF, 10'h000, 1'b0, '0);
        add_row(ACT_BYTE, 8'hFF, 10'h000, 1'b0, '0);
        // zero step count: dir rises, then drops at once
        add_row(ACT_BYTE, OP_MOVE_FWD, 10'h000, 1'b0, '0);
        add_row(ACT_BYTE, 8'h00, 10'h000, 1'b0, '0);
        add_row(ACT_BYTE, 8'h00, 10'h000, 1'b0, '0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
        repeat (RANDOM_ITEMS)
            send_item(next_random_item(), 1'b0, '0);
        cmd_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/scpg_pkg.sv
rtl/scpg_ctrl.sv
rtl/stepper_command_pulse_generator_core.sv
sim/tb_stepper_command_pulse_generator_core.sv
